/* rtl/core/h264ns_pkg.sv */
// Shared types and constants for the Annex B NAL unit splitter.
`timescale 1ns / 1ps

package h264ns_pkg;

   // Widths of the result fields.
   localparam int OFFSET_W = 20;
   localparam int LENGTH_W = 21;
   localparam int CODE_W   = 3;
   localparam int TYPE_W   = 5;
   localparam int TIME_W   = 32;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Start code lengths.
   localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_SHORT = 3'd3;
   localparam logic [CODE_W-1:0] CODE_LONG  = 3'd4;

   // NAL unit types that mark a keyframe.
   localparam logic [TYPE_W-1:0] TYPE_IDR = 5'd5;
   localparam logic [TYPE_W-1:0] TYPE_SPS = 5'd7;
   localparam logic [TYPE_W-1:0] TYPE_PPS = 5'd8;

   // One closed unit as the front hands it to the back. Positions are kept
   // modulo 2^LENGTH_W so the back can form the length with one subtract.
   typedef struct packed {
      logic [LENGTH_W-1:0] start_pos;
      logic [LENGTH_W-1:0] end_pos;
      logic [CODE_W-1:0]   code_length;
      logic [TYPE_W-1:0]   unit_type;
      logic [TIME_W-1:0]   unit_time;
      logic                final_unit;
   } unit_rec_type;

endpackage

/* rtl/core/h264ns_front.sv */
// Front end: byte window, start code detection and open unit tracking.
`timescale 1ns / 1ps

module h264ns_front #(
   parameter int BUFFER_BYTES = 1048576
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   input  logic [h264ns_pkg::TIME_W-1:0]      req_frame_time,
   input  logic                               queue_full,
   output logic                               push,
   output h264ns_pkg::unit_rec_type           push_rec
);

   localparam int POS_W = $clog2(BUFFER_BYTES);
   localparam int EXT_W = (POS_W + 1 > h264ns_pkg::LENGTH_W) ? POS_W + 1
                                                             : h264ns_pkg::LENGTH_W;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);

   logic [23:0]                       win_ff, win_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic                              open_ff, open_in;
   logic [POS_W-1:0]                  off_ff, off_in;
   logic [h264ns_pkg::CODE_W-1:0]     code_ff, code_in;
   logic [h264ns_pkg::TYPE_W-1:0]     type_ff, type_in;

   logic                              accept;
   logic [31:0]                       window;
   logic                              is_end;
   logic                              hdr_upd;
   logic [h264ns_pkg::TYPE_W-1:0]     type_cur;
   logic [POS_W-1:0]                  q_pos;
   logic [h264ns_pkg::CODE_W-1:0]     code_det;
   logic                              code_hit;
   logic [POS_W:0]                    open_limit;
   logic [EXT_W-1:0]                  start_ext;
   logic [EXT_W-1:0]                  end_ext;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Detection of start codes and the next state of the open unit.
   always_comb begin
      window     = {win_ff, req_data_byte};
      is_end     = req_last_byte || (pos_ff >= LAST_POS);
      hdr_upd    = open_ff && (code_ff == h264ns_pkg::CODE_LONG) &&
                   ({1'b0, pos_ff} == ({1'b0, off_ff} + (POS_W + 1)'(4)));
      type_cur   = hdr_upd ? req_data_byte[h264ns_pkg::TYPE_W-1:0] : type_ff;
      q_pos      = pos_ff - POS_W'(3);
      open_limit = {1'b0, off_ff} + (POS_W + 1)'(code_ff);

      code_det = h264ns_pkg::CODE_NONE;
      if (pos_ff >= POS_W'(3)) begin
         if (window[31:8] == 24'h000001) begin
            code_det = h264ns_pkg::CODE_SHORT;
         end else if (window == 32'h0000_0001) begin
            code_det = h264ns_pkg::CODE_LONG;
         end
      end
      // A start code inside the open unit's start code or header is ignored.
      code_hit = (code_det != h264ns_pkg::CODE_NONE) &&
                 !(open_ff && ({1'b0, q_pos} <= open_limit));

      // The open unit closes on a new start code, on the last byte or at the end of the buffer.
      push      = accept && open_ff && (code_hit || is_end);
      start_ext = EXT_W'(off_ff);
      end_ext   = code_hit ? EXT_W'(q_pos) : EXT_W'({1'b0, pos_ff} + (POS_W + 1)'(1));
      push_rec.start_pos   = start_ext[h264ns_pkg::LENGTH_W-1:0];
      push_rec.end_pos     = end_ext[h264ns_pkg::LENGTH_W-1:0];
      push_rec.code_length = code_ff;
      push_rec.unit_type   = type_cur;
      push_rec.unit_time   = req_frame_time;
      push_rec.final_unit  = is_end;

      // Next state.
      if (is_end) begin
         win_in  = 24'h0;
         pos_in  = '0;
         open_in = 1'b0;
         off_in  = '0;
         code_in = h264ns_pkg::CODE_NONE;
         type_in = '0;
      end else begin
         win_in = window[23:0];
         pos_in = pos_ff + POS_W'(1);
         if (code_hit) begin
            open_in = 1'b1;
            off_in  = q_pos;
            code_in = code_det;
            type_in = (code_det == h264ns_pkg::CODE_SHORT) ?
                      req_data_byte[h264ns_pkg::TYPE_W-1:0] : '0;
         end else begin
            open_in = open_ff;
            off_in  = off_ff;
            code_in = code_ff;
            type_in = type_cur;
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= 24'h0;
         pos_ff  <= '0;
         open_ff <= 1'b0;
         off_ff  <= '0;
         code_ff <= h264ns_pkg::CODE_NONE;
         type_ff <= '0;
      end else if (accept) begin
         win_ff  <= win_in;
         pos_ff  <= pos_in;
         open_ff <= open_in;
         off_ff  <= off_in;
         code_ff <= code_in;
         type_ff <= type_in;
      end
   end

endmodule

/* rtl/core/h264ns_queue.sv */
// Short queue of closed units between the front and the back.
`timescale 1ns / 1ps

module h264ns_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  h264ns_pkg::unit_rec_type  push_rec,
   output logic                      full,
   output logic                      not_empty,
   input  logic                      pop,
   output h264ns_pkg::unit_rec_type  head_rec
);

   localparam int PTR_W = h264ns_pkg::QUEUE_PTR_W;
   localparam int CNT_W = PTR_W + 1;

   h264ns_pkg::unit_rec_type entry_ff [h264ns_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(h264ns_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_rec  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* rtl/core/h264ns_back.sv */
// Back end: forms length and keyframe flag and holds the response register.
`timescale 1ns / 1ps

module h264ns_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  h264ns_pkg::unit_rec_type            head_rec,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [h264ns_pkg::OFFSET_W-1:0]     rsp_unit_offset,
   output logic [h264ns_pkg::LENGTH_W-1:0]     rsp_unit_length,
   output logic [h264ns_pkg::CODE_W-1:0]       rsp_code_length,
   output logic [h264ns_pkg::TYPE_W-1:0]       rsp_unit_type,
   output logic                                rsp_keyframe,
   output logic [h264ns_pkg::TIME_W-1:0]       rsp_unit_time,
   output logic                                rsp_final_unit
);

   logic                               valid_ff, valid_in;
   logic [h264ns_pkg::OFFSET_W-1:0]    offset_ff;
   logic [h264ns_pkg::LENGTH_W-1:0]    length_ff, length_in;
   logic [h264ns_pkg::CODE_W-1:0]      code_ff;
   logic [h264ns_pkg::TYPE_W-1:0]      type_ff;
   logic                               key_ff, key_in;
   logic [h264ns_pkg::TIME_W-1:0]      time_ff;
   logic                               final_ff;

   // Take the queue head when the response register is free or draining.
   always_comb begin
      pop = head_valid && (!valid_ff || !rsp_stall);
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      length_in = head_rec.end_pos - head_rec.start_pos;
      key_in    = (head_rec.unit_type == h264ns_pkg::TYPE_IDR) ||
                  (head_rec.unit_type == h264ns_pkg::TYPE_SPS) ||
                  (head_rec.unit_type == h264ns_pkg::TYPE_PPS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         offset_ff <= head_rec.start_pos[h264ns_pkg::OFFSET_W-1:0];
         length_ff <= length_in;
         code_ff   <= head_rec.code_length;
         type_ff   <= head_rec.unit_type;
         key_ff    <= key_in;
         time_ff   <= head_rec.unit_time;
         final_ff  <= head_rec.final_unit;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_unit_offset = offset_ff;
   assign rsp_unit_length = length_ff;
   assign rsp_code_length = code_ff;
   assign rsp_unit_type   = type_ff;
   assign rsp_keyframe    = key_ff;
   assign rsp_unit_time   = time_ff;
   assign rsp_final_unit  = final_ff;

endmodule

/* rtl/core/h264_annexb_nal_splitter_core.sv */
// Top level of the Annex B NAL unit splitter.
// Throughput: one byte request per cycle, set by the parser loop, while the unit queue is not full.
// A closed unit is written to the unit queue, then moved to the response register when it is free or draining.
// The four-entry unit queue lets the byte side run while a response waits.
// Reset clears the parser window, position, open unit and queue at once.
`timescale 1ns / 1ps

module h264_annexb_nal_splitter_core #(
   parameter int BUFFER_BYTES = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   input  logic [h264ns_pkg::TIME_W-1:0]       req_frame_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [h264ns_pkg::OFFSET_W-1:0]     rsp_unit_offset,
   output logic [h264ns_pkg::LENGTH_W-1:0]     rsp_unit_length,
   output logic [h264ns_pkg::CODE_W-1:0]       rsp_code_length,
   output logic [h264ns_pkg::TYPE_W-1:0]       rsp_unit_type,
   output logic                                rsp_keyframe,
   output logic [h264ns_pkg::TIME_W-1:0]       rsp_unit_time,
   output logic                                rsp_final_unit
);

   logic                      push;
   h264ns_pkg::unit_rec_type  push_rec;
   logic                      queue_full;
   logic                      queue_not_empty;
   logic                      pop;
   h264ns_pkg::unit_rec_type  head_rec;

   // Byte parser.
   h264ns_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .req_frame_time (req_frame_time),
      .queue_full     (queue_full),
      .push           (push),
      .push_rec       (push_rec)
   );

   // Unit queue.
   h264ns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head_rec  (head_rec)
   );

   // Response stage.
   h264ns_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (queue_not_empty),
      .head_rec        (head_rec),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_unit_offset (rsp_unit_offset),
      .rsp_unit_length (rsp_unit_length),
      .rsp_code_length (rsp_code_length),
      .rsp_unit_type   (rsp_unit_type),
      .rsp_keyframe    (rsp_keyframe),
      .rsp_unit_time   (rsp_unit_time),
      .rsp_final_unit  (rsp_final_unit)
   );

endmodule
